FILE: src/nrd_pkg.sv
package nrd_pkg;

    // Extra bits the partial remainder carries above the operand width so that
    // it holds a sign and never wraps.
    localparam int PART_GUARD = 1;

    // Extra bit on the shifted value inside one iteration, before the add or
    // subtract brings it back into range.
    localparam int SHIFT_GUARD = 1;

endpackage

FILE: src/nrd_if.sv
// Request channel: one division per request.
interface nrd_req_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// Response channel: quotient, remainder and the zero-divisor flag.
interface nrd_rsp_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             div_by_zero;

    modport source (output valid, output quotient, output remainder,
                    output div_by_zero, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input div_by_zero, output ready);
endinterface

FILE: src/nrd_step.sv
// One non-restoring iteration followed by its pipeline register.
// The accumulator enters holding the dividend bits still to be consumed in its
// upper part and leaves with one more quotient bit shifted in at the bottom.
module nrd_step
    import nrd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [WIDTH+PART_GUARD-1:0] in_part,
    input  logic [WIDTH-1:0]           in_acc,
    input  logic [WIDTH-1:0]           in_dvs,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [WIDTH+PART_GUARD-1:0] out_part,
    output logic [WIDTH-1:0]           out_acc,
    output logic [WIDTH-1:0]           out_dvs
);

    localparam int PW = WIDTH + PART_GUARD;
    localparam int SW = PW + SHIFT_GUARD;

    logic          valid_reg;
    logic [PW-1:0] part_reg;
    logic [PW-1:0] part_next;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] dvs_reg;
    logic [SW-1:0] shifted;
    logic [SW-1:0] dvs_ext;
    logic [SW-1:0] sum;
    logic          load;

    // Shift in the next dividend bit, then add or subtract by the old sign.
    always_comb
    begin
        shifted   = {in_part, in_acc[WIDTH-1]};
        dvs_ext   = {{(SW-WIDTH){1'b0}}, in_dvs};
        sum       = in_part[PW-1] ? (shifted + dvs_ext) : (shifted - dvs_ext);
        part_next = sum[PW-1:0];
        acc_next  = {in_acc[WIDTH-2:0], ~sum[PW-1]};
    end

    // The stage takes a new item when it is empty or its content moves on.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            part_reg <= part_next;
            acc_reg  <= acc_next;
            dvs_reg  <= in_dvs;
        end
    end

    assign out_valid = valid_reg;
    assign out_part  = part_reg;
    assign out_acc   = acc_reg;
    assign out_dvs   = dvs_reg;

endmodule

FILE: src/nrd_fix.sv
// Final correction of a negative remainder and the output register.
module nrd_fix
    import nrd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [WIDTH+PART_GUARD-1:0] in_part,
    input  logic [WIDTH-1:0]            in_acc,
    input  logic [WIDTH-1:0]            in_dvs,
    nrd_rsp_if.source                   rsp
);

    localparam int PW = WIDTH + PART_GUARD;

    logic             valid_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] dvs_reg;
    logic             dbz_reg;
    logic             dbz_next;
    logic [PW-1:0]    fixed;
    logic             load;

    // A negative remainder gets the divisor added back once. With a zero
    // divisor the iterations leave the dividend itself and all-ones bits.
    always_comb
    begin
        fixed    = in_part[PW-1] ? (in_part + {{PART_GUARD{1'b0}}, in_dvs}) : in_part;
        rem_next = fixed[WIDTH-1:0];
        dbz_next = (in_dvs == '0);
    end

    assign in_ready = !valid_reg || rsp.ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= in_acc;
            rem_reg <= rem_next;
            dvs_reg <= in_dvs;
            dbz_reg <= dbz_next;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.quotient    = quo_reg;
    assign rsp.remainder   = rem_reg;
    assign rsp.div_by_zero = dbz_reg;

`ifndef NO_ASSERTIONS
    // A zero divisor must come out as an all-ones quotient.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && dbz_reg |-> quo_reg == '1)
        else $error("zero divisor without all-ones quotient");

    // A real division must leave a remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dbz_reg |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");

    // A stalled result must be held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !rsp.ready |=> valid_reg && $stable(quo_reg) && $stable(rem_reg))
        else $error("stalled result changed");
`endif

endmodule

FILE: src/non_restoring_divider.sv
// Unsigned non-restoring divider, fully pipelined.
// A request on req carries dividend and divisor, WIDTH bits each; a response
// on rsp carries quotient, remainder and div_by_zero for every request, in
// request order. Both channels move an item on a clock edge where valid and
// ready are both high.
// A request passes one register stage per quotient bit, then the remainder
// correction stage, which is also the output register. A new request is
// accepted every cycle unless a stall backs up to req.ready, so throughput is
// one division per cycle while the receiver keeps ready high.
// A zero divisor flags div_by_zero, returns an all-ones quotient and the
// dividend as remainder.
// Reset (rst_n low, asynchronous) empties every stage; no response is pending
// afterwards. When the receiver holds ready low, the response is held and each
// stage keeps its item while the next one is full, so the stall walks back to
// req.ready; nothing is lost or repeated.
module non_restoring_divider
    import nrd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    nrd_req_if.sink   req,
    nrd_rsp_if.source rsp
);

    localparam int PW = WIDTH + PART_GUARD;

    // Links between stages; link 0 is the request port.
    logic             vld_c  [WIDTH+1];
    logic             rdy_c  [WIDTH+1];
    logic [PW-1:0]    part_c [WIDTH+1];
    logic [WIDTH-1:0] acc_c  [WIDTH+1];
    logic [WIDTH-1:0] dvs_c  [WIDTH+1];

    assign vld_c[0]  = req.valid;
    assign req.ready = rdy_c[0];
    assign part_c[0] = '0;
    assign acc_c[0]  = req.dividend;
    assign dvs_c[0]  = req.divisor;

    // One iteration stage per quotient bit.
    for (genvar i = 0; i < WIDTH; i++)
    begin : g_step
        nrd_step #(
            .WIDTH (WIDTH)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld_c[i]),
            .in_ready  (rdy_c[i]),
            .in_part   (part_c[i]),
            .in_acc    (acc_c[i]),
            .in_dvs    (dvs_c[i]),
            .out_valid (vld_c[i+1]),
            .out_ready (rdy_c[i+1]),
            .out_part  (part_c[i+1]),
            .out_acc   (acc_c[i+1]),
            .out_dvs   (dvs_c[i+1])
        );
    end

    // Remainder correction and output register.
    nrd_fix #(
        .WIDTH (WIDTH)
    ) u_fix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld_c[WIDTH]),
        .in_ready (rdy_c[WIDTH]),
        .in_part  (part_c[WIDTH]),
        .in_acc   (acc_c[WIDTH]),
        .in_dvs   (dvs_c[WIDTH]),
        .rsp      (rsp)
    );

endmodule

FILE: tb/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    // Keeps the expected results of accepted requests and compares responses.
    class division_ledger;

        typedef struct packed {
            logic [W-1:0] quotient;
            logic [W-1:0] remainder;
            logic         div_by_zero;
        } div_result_t;

        div_result_t awaited[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Non-restoring division over a signed partial remainder with two guard bits.
        function automatic div_result_t divide_nonrestoring(logic [W-1:0] dvd,
                                                            logic [W-1:0] dvs);
            logic signed [W+1:0] part;
            logic signed [W+1:0] d;
            logic [W-1:0]        quo;
            logic                nonneg;
            div_result_t         res;

            if (dvs == '0)
            begin
                res.quotient    = '1;
                res.remainder   = dvd;
                res.div_by_zero = 1'b1;
                return res;
            end
            part = '0;
            d    = $signed({2'b00, dvs});
            quo  = '0;
            for (int i = W - 1; i >= 0; i--)
            begin
                // The add or subtract choice follows the sign before the shift.
                nonneg = !part[W+1];
                part   = {part[W:0], dvd[i]};
                part   = nonneg ? part - d : part + d;
                quo    = {quo[W-2:0], !part[W+1]};
            end
            // A negative final remainder gets one corrective add.
            if (part[W+1])
                part = part + d;
            res.quotient    = quo;
            res.remainder   = part[W-1:0];
            res.div_by_zero = 1'b0;
            return res;
        endfunction

        function void note_request(logic [W-1:0] dvd, logic [W-1:0] dvs);
            awaited.push_back(divide_nonrestoring(dvd, dvs));
        endfunction

        function void check_response(logic [W-1:0] quo, logic [W-1:0] rem,
                                     logic dbz);
            div_result_t want;

            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: response with nothing awaited: q=%0d r=%0d dbz=%0b",
                             $time, quo, rem, dbz);
                return;
            end
            want = awaited.pop_front();
            if (quo !== want.quotient || rem !== want.remainder
                || dbz !== want.div_by_zero)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: mismatch: expected q=%0d r=%0d dbz=%0b, ",
                              "got q=%0d r=%0d dbz=%0b"},
                             $time, want.quotient, want.remainder, want.div_by_zero,
                             quo, rem, dbz);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

    endclass

    logic clk;
    logic rst_n;

    nrd_req_if #(.WIDTH(W)) req_ch ();
    nrd_rsp_if #(.WIDTH(W)) rsp_ch ();

    non_restoring_divider #(
        .WIDTH(W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    division_ledger ledger;

    int send_idle_pct;
    int recv_idle_pct;
    bit long_hold_go;
    int long_hold_left;
    int quiet_cycles;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (long_hold_left > 0)
        begin
            long_hold_left = long_hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (long_hold_go)
        begin
            long_hold_go   = 1'b0;
            long_hold_left = LONG_HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Both channels are sampled at the edge; the watchdog counts quiet cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                ledger.note_request(req_ch.dividend, req_ch.divisor);
            if (rsp_ch.valid && rsp_ch.ready)
                ledger.check_response(rsp_ch.quotient, rsp_ch.remainder,
                                      rsp_ch.div_by_zero);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Offers one request, idling first at random, and waits until it is taken.
    task automatic send_division(input logic [W-1:0] dvd, input logic [W-1:0] dvs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.dividend <= dvd;
        req_ch.divisor  <= dvs;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Random pairs biased to zero, small and 2^k divisors, dividend < divisor, edges.
    task automatic send_random(input int count);
        logic [W-1:0] dvd;
        logic [W-1:0] dvs;
        logic [W-1:0] edges[6];

        edges = '{'0, W'(1), {1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}},
                  {{(W-1){1'b1}}, 1'b0}, '1};
        for (int n = 0; n < count; n++)
        begin
            dvd = W'($urandom_range((1 << W) - 1));
            dvs = W'($urandom_range((1 << W) - 1));
            case ($urandom_range(9))
                0: dvs = '0;
                1: dvs = W'($urandom_range(15, 1));
                2:
                begin
                    if (dvs == '0)
                        dvs = W'(1);
                    dvd = W'($urandom_range(dvs - 1));
                end
                3:
                begin
                    dvd = edges[$urandom_range(5)];
                    dvs = edges[$urandom_range(5)];
                end
                4: dvs = W'(1) << $urandom_range(W - 1);
                default: ;
            endcase
            send_division(dvd, dvs);
        end
    endtask

    // Drops valid and waits until every awaited response has come back.
    // The first edge lets the last accepted request reach the ledger.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        ledger          = new();
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.dividend = '0;
        req_ch.divisor  = '0;
        rsp_ch.ready    = 1'b0;
        send_idle_pct   = 24;
        recv_idle_pct   = 49;
        long_hold_go    = 1'b0;
        long_hold_left  = 0;
        quiet_cycles    = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero divisors, unit divisors, full-scale operands and near misses.
        send_division(8'd0,   8'd0);
        send_division(8'd255, 8'd0);
        send_division(8'd170, 8'd0);
        send_division(8'd0,   8'd1);
        send_division(8'd255, 8'd1);
        send_division(8'd255, 8'd255);
        send_division(8'd0,   8'd255);
        send_division(8'd254, 8'd255);
        send_division(8'd255, 8'd254);
        send_division(8'd128, 8'd1);
        send_division(8'd1,   8'd128);
        send_division(8'd127, 8'd128);
        send_division(8'd128, 8'd127);
        send_division(8'd200, 8'd7);
        send_division(8'd170, 8'd85);
        send_division(8'd85,  8'd170);
        send_division(8'd1,   8'd1);
        send_division(8'd255, 8'd2);
        send_division(8'd100, 8'd10);
        send_division(8'd129, 8'd128);

        send_random(520);

        // Long receiver hold-off while requests keep coming, so the pipe backs up.
        long_hold_go = 1'b1;
        send_random(40);

        // Pause the sender until every result is back.
        drain_results();

        send_idle_pct = 49;
        recv_idle_pct = 24;
        send_random(520);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(520);

        drain_results();
        repeat (2 * W + 8) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/nrd_pkg.sv
src/nrd_if.sv
src/nrd_step.sv
src/nrd_fix.sv
src/non_restoring_divider.sv
tb/tb.sv
